// File: design/assert_macros.svh
// Assertion macros shared by the RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_HOLDS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_HOLDS(lbl, clk, rst, expr, msg)
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// File: design/bsalu_pkg.sv
// Shared types and constants for the shifter ALU.
// No dependencies; used by the front, queue, back and top modules.
`default_nettype none

package bsalu_pkg;

   localparam int BSALU_Q_DEPTH = 2;
   localparam int BSALU_Q_PTR_W = (BSALU_Q_DEPTH > 1) ? $clog2(BSALU_Q_DEPTH) : 1;
   localparam int BSALU_Q_CNT_W = $clog2(BSALU_Q_DEPTH + 1);

   typedef enum logic [3:0] {
      OP_AND = 4'b0000,
      OP_EOR = 4'b0001,
      OP_SUB = 4'b0010,
      OP_RSB = 4'b0011,
      OP_ADD = 4'b0100,
      OP_ADC = 4'b0101,
      OP_SBC = 4'b0110,
      OP_RSC = 4'b0111,
      OP_TST = 4'b1000,
      OP_TEQ = 4'b1001,
      OP_CMP = 4'b1010,
      OP_CMN = 4'b1011,
      OP_ORR = 4'b1100,
      OP_MOV = 4'b1101,
      OP_BIC = 4'b1110,
      OP_MVN = 4'b1111
   } bsalu_opcode_type;

   typedef enum logic [1:0] {
      SHIFT_LSL = 2'b00,
      SHIFT_LSR = 2'b01,
      SHIFT_ASR = 2'b10,
      SHIFT_ROR = 2'b11
   } bsalu_shift_type;

   // decoded operation waiting in the queue
   typedef struct packed {
      bsalu_opcode_type opcode;
      logic [31:0]      first_operand;
      logic [31:0]      operand_b;
      logic             shift_carry;
      logic             carry_in;
      logic             overflow_in;
      logic             write_result;
      logic             is_arith;
      logic             flags_written;
      logic             restore_status;
   } bsalu_op_type;

   typedef struct packed {
      logic full;
      logic empty;
   } bsalu_q_status_type;

endpackage

`default_nettype wire

// File: design/bsalu_if.sv
// Valid/ready channel interfaces for request and response beats.
// No dependencies.
`default_nettype none

interface bsalu_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  action;
   logic [31:0] first_operand;
   logic [31:0] second_source;
   logic        immediate_form;
   logic [3:0]  rotate_field;
   logic        register_shift;
   logic [1:0]  shift_kind;
   logic [7:0]  shift_amount;
   logic        carry_in;
   logic        overflow_in;
   logic        set_flags;
   logic        dest_is_pc;

   modport source (
      output valid, action, first_operand, second_source, immediate_form, rotate_field,
             register_shift, shift_kind, shift_amount, carry_in, overflow_in, set_flags,
             dest_is_pc,
      input  ready
   );
   modport sink (
      input  valid, action, first_operand, second_source, immediate_form, rotate_field,
             register_shift, shift_kind, shift_amount, carry_in, overflow_in, set_flags,
             dest_is_pc,
      output ready
   );
endinterface

interface bsalu_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] result;
   logic        write_result;
   logic        negative_out;
   logic        zero_out;
   logic        carry_out;
   logic        overflow_out;
   logic        flags_written;
   logic        restore_saved_status;

   modport source (
      output valid, result, write_result, negative_out, zero_out, carry_out,
             overflow_out, flags_written, restore_saved_status,
      input  ready
   );
   modport sink (
      input  valid, result, write_result, negative_out, zero_out, carry_out,
             overflow_out, flags_written, restore_saved_status,
      output ready
   );
endinterface

`default_nettype wire

// File: design/barrel_shift_alu_with_flags.sv
// A request beat accepted on req is queued, then registered for rsp. Throughput: one
// beat per cycle unless rsp stalls; a two-entry queue sits between decode/shift and
// the ALU output register, so either side can stall without stopping the other.
// Reset: synchronous, active high; clears queue pointers and the response valid.
// Top level: instantiates front, queue and back; depends on bsalu_pkg, bsalu_if.
`default_nettype none
`include "assert_macros.svh"

module barrel_shift_alu_with_flags
   import bsalu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   bsalu_req_if.sink   req_ch,
   bsalu_rsp_if.source rsp_ch
);

   logic               push;
   logic               pop;
   bsalu_op_type       push_data;
   bsalu_op_type       pop_data;
   bsalu_q_status_type q_status;

   bsalu_front u_front (
      .req_ch    (req_ch),
      .q_full    (q_status.full),
      .push      (push),
      .push_data (push_data)
   );

   bsalu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   bsalu_back u_back (
      .clock    (clock),
      .reset    (reset),
      .op_valid (!q_status.empty),
      .op       (pop_data),
      .pop      (pop),
      .rsp_ch   (rsp_ch)
   );

   `ASSERT_HOLDS(a_flags_excl, clock, reset,
      !(rsp_ch.valid && rsp_ch.flags_written && rsp_ch.restore_saved_status),
      "flag write and status restore both set")
   `ASSERT_NEXT(a_push_lands, clock, reset, req_ch.valid && req_ch.ready,
      !q_status.empty || rsp_ch.valid, "accepted beat lost")
   `ASSERT_IMPL(a_pop_nonempty, clock, reset, pop, !q_status.empty,
      "pop from empty queue")
   `ASSERT_IMPL(a_full_blocks, clock, reset, q_status.full, !req_ch.ready,
      "ready high with queue full")

endmodule

`default_nettype wire

// File: design/bsalu_front.sv
// Front end: accepts request beats, decodes the opcode and builds the shifted operand.
// Depends on bsalu_pkg and bsalu_req_if.
`default_nettype none

module bsalu_front
   import bsalu_pkg::*;
(
   bsalu_req_if.sink    req_ch,
   input  logic         q_full,
   output logic         push,
   output bsalu_op_type push_data
);

   bsalu_opcode_type opcode;
   bsalu_shift_type  kind;
   logic [31:0]      src;
   logic [31:0]      imm_word;
   logic [4:0]       rot_amt;
   logic [63:0]      imm_dbl;
   logic [31:0]      imm_val;
   logic             imm_c;
   logic [7:0]       amt;
   logic [4:0]       amt_lo;
   logic             amt_big;
   logic             amt_zero;
   logic             amt_32;
   logic             regsh;
   logic             cin;
   logic             msb;
   logic [32:0]      lsl_w;
   logic [32:0]      lsr_w;
   logic [32:0]      asr_w;
   logic [63:0]      ror_w;
   logic [31:0]      sh_val;
   logic             sh_c;

   assign opcode   = bsalu_opcode_type'(req_ch.action);
   assign kind     = bsalu_shift_type'(req_ch.shift_kind);
   assign src      = req_ch.second_source;
   assign regsh    = req_ch.register_shift;
   assign cin      = req_ch.carry_in;
   assign msb      = src[31];

   // rotated 8-bit immediate
   assign imm_word = {24'd0, src[7:0]};
   assign rot_amt  = {req_ch.rotate_field, 1'b0};
   assign imm_dbl  = {imm_word, imm_word} >> rot_amt;
   assign imm_val  = imm_dbl[31:0];
   assign imm_c    = (req_ch.rotate_field == 4'd0) ? cin : imm_val[31];

   // shifted register
   assign amt      = regsh ? req_ch.shift_amount : {3'b000, req_ch.shift_amount[4:0]};
   assign amt_lo   = amt[4:0];
   assign amt_big  = |amt[7:5];
   assign amt_zero = (amt == 8'd0);
   assign amt_32   = (amt == 8'd32);

   assign lsl_w    = {1'b0, src} << amt_lo;
   assign lsr_w    = {src, 1'b0} >> amt_lo;
   assign asr_w    = 33'($signed({src, 1'b0}) >>> amt_lo);
   assign ror_w    = {src, src} >> amt_lo;

   always_comb begin
      sh_val = src;
      sh_c   = cin;
      case (kind)
         SHIFT_LSL: begin
            if (amt_big) begin
               sh_val = 32'd0;
               sh_c   = amt_32 & src[0];
            end else if (!amt_zero) begin
               sh_val = lsl_w[31:0];
               sh_c   = lsl_w[32];
            end
         end
         SHIFT_LSR: begin
            if (amt_big || (amt_zero && !regsh)) begin
               sh_val = 32'd0;
               sh_c   = (amt_32 || amt_zero) & msb;
            end else if (!amt_zero) begin
               sh_val = lsr_w[32:1];
               sh_c   = lsr_w[0];
            end
         end
         SHIFT_ASR: begin
            if (amt_big || (amt_zero && !regsh)) begin
               sh_val = {32{msb}};
               sh_c   = msb;
            end else if (!amt_zero) begin
               sh_val = asr_w[32:1];
               sh_c   = asr_w[0];
            end
         end
         SHIFT_ROR: begin
            if (amt_zero) begin
               if (!regsh) begin
                  sh_val = {cin, src[31:1]};
                  sh_c   = src[0];
               end
            end else begin
               // multiple of 32 leaves the value and gives bit 31 as carry
               sh_val = ror_w[31:0];
               sh_c   = ror_w[31];
            end
         end
         default: begin
            sh_val = src;
            sh_c   = cin;
         end
      endcase
   end

   assign req_ch.ready = !q_full;
   assign push         = req_ch.valid && !q_full;

   always_comb begin
      push_data.opcode         = opcode;
      push_data.first_operand  = req_ch.first_operand;
      push_data.operand_b      = req_ch.immediate_form ? imm_val : sh_val;
      push_data.shift_carry    = req_ch.immediate_form ? imm_c : sh_c;
      push_data.carry_in       = cin;
      push_data.overflow_in    = req_ch.overflow_in;
      push_data.write_result   = !(opcode inside {OP_TST, OP_TEQ, OP_CMP, OP_CMN});
      push_data.is_arith       = opcode inside {[OP_SUB:OP_RSC], OP_CMP, OP_CMN};
      push_data.flags_written  = req_ch.set_flags && !req_ch.dest_is_pc;
      push_data.restore_status = req_ch.set_flags && req_ch.dest_is_pc;
   end

endmodule

`default_nettype wire

// File: design/bsalu_queue.sv
// Short queue of decoded operations between front and back.
// Depends on bsalu_pkg.
`default_nettype none

module bsalu_queue
   import bsalu_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  bsalu_op_type       push_data,
   input  logic               pop,
   output bsalu_op_type       pop_data,
   output bsalu_q_status_type status
);

   localparam logic [BSALU_Q_PTR_W-1:0] LastPtr = BSALU_Q_PTR_W'(BSALU_Q_DEPTH - 1);
   localparam logic [BSALU_Q_CNT_W-1:0] FullCnt = BSALU_Q_CNT_W'(BSALU_Q_DEPTH);

   bsalu_op_type                 entry_ff [BSALU_Q_DEPTH];
   logic [BSALU_Q_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [BSALU_Q_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [BSALU_Q_CNT_W-1:0]     count_ff, count_in;
   logic                         do_push;
   logic                         do_pop;

   assign status.full  = (count_ff == FullCnt);
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: design/bsalu_back.sv
// Back end: ALU and flag logic, result held in the response output register.
// Depends on bsalu_pkg and bsalu_rsp_if.
`default_nettype none

module bsalu_back
   import bsalu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         op_valid,
   input  bsalu_op_type op,
   output logic         pop,
   bsalu_rsp_if.source  rsp_ch
);

   logic [31:0] a;
   logic [31:0] b;
   logic [31:0] add_x;
   logic [31:0] add_y;
   logic        add_ci;
   logic [32:0] sum;
   logic        add_v;
   logic [31:0] res;
   logic        c_new;
   logic        v_new;

   logic        valid_ff, valid_in;
   logic [31:0] result_ff;
   logic        write_ff;
   logic        carry_ff;
   logic        overflow_ff;
   logic        flags_ff;
   logic        restore_ff;

   assign a = op.first_operand;
   assign b = op.operand_b;

   always_comb begin
      add_x  = a;
      add_y  = b;
      add_ci = 1'b0;
      case (op.opcode)
         OP_SUB, OP_CMP: begin
            add_y  = ~b;
            add_ci = 1'b1;
         end
         OP_RSB: begin
            add_x  = b;
            add_y  = ~a;
            add_ci = 1'b1;
         end
         OP_ADC: begin
            add_ci = op.carry_in;
         end
         OP_SBC: begin
            add_y  = ~b;
            add_ci = op.carry_in;
         end
         OP_RSC: begin
            add_x  = b;
            add_y  = ~a;
            add_ci = op.carry_in;
         end
         default: begin
            add_x  = a;
            add_y  = b;
            add_ci = 1'b0;
         end
      endcase
   end

   assign sum   = {1'b0, add_x} + {1'b0, add_y} + {32'd0, add_ci};
   assign add_v = ~(add_x[31] ^ add_y[31]) & (add_x[31] ^ sum[31]);

   always_comb begin
      case (op.opcode)
         OP_AND, OP_TST: res = a & b;
         OP_EOR, OP_TEQ: res = a ^ b;
         OP_ORR:         res = a | b;
         OP_MOV:         res = b;
         OP_BIC:         res = a & ~b;
         OP_MVN:         res = ~b;
         default:        res = sum[31:0];
      endcase
   end

   assign c_new = op.is_arith ? sum[32] : op.shift_carry;
   assign v_new = op.is_arith ? add_v : op.overflow_in;

   assign pop      = op_valid && (!valid_ff || rsp_ch.ready);
   assign valid_in = pop ? 1'b1 : (rsp_ch.ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         result_ff   <= res;
         write_ff    <= op.write_result;
         carry_ff    <= c_new;
         overflow_ff <= v_new;
         flags_ff    <= op.flags_written;
         restore_ff  <= op.restore_status;
      end
   end

   assign rsp_ch.valid                = valid_ff;
   assign rsp_ch.result               = result_ff;
   assign rsp_ch.write_result         = write_ff;
   assign rsp_ch.negative_out         = result_ff[31];
   assign rsp_ch.zero_out             = (result_ff == 32'd0);
   assign rsp_ch.carry_out            = carry_ff;
   assign rsp_ch.overflow_out         = overflow_ff;
   assign rsp_ch.flags_written        = flags_ff;
   assign rsp_ch.restore_saved_status = restore_ff;

endmodule

`default_nettype wire
